// ===== hdl/ens_pkg.sv =====
package ens_pkg;

  // Table geometry
  localparam int unsigned SLOTS = 8;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  // Lifetime defaults and conversion
  localparam int unsigned DEF_FREQ    = 1000;
  localparam int unsigned DEF_LIFE_MS = 5000;
  localparam int unsigned MS_PER_S    = 1000;

  // Constant divider: radix-16 restoring steps over a 64-bit product
  localparam int unsigned DIV_W     = 64;
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned DIV_STEPS = DIV_W / DIV_BITS;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
  localparam int unsigned REM_W     = $clog2(MS_PER_S);

  typedef enum logic [2:0] {
    OP_NOTIFY  = 3'd0,
    OP_SWEEP   = 3'd1,
    OP_DISMISS = 3'd2,
    OP_COUNT   = 3'd3,
    OP_GET     = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SWEEP,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] now_tick;
    logic [31:0] lifetime_ms;
    logic        has_text;
    logic [31:0] message_tag;
    logic [63:0] target_id;
    logic [5:0]  nth;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [5:0]  slot;
    logic [63:0] entry_id;
    logic [63:0] expiry_tick;
    logic [31:0] entry_tag;
    logic [6:0]  active_count;
    logic [63:0] posted_total;
  } resp_t;

  // Write side of the entry store
  typedef struct packed {
    logic             wr;
    logic             clr;
    logic [IDX_W-1:0] widx;
    logic [63:0]      id;
    logic [63:0]      expiry;
    logic [31:0]      tag;
  } store_cmd_t;

  // Read side of the entry store
  typedef struct packed {
    logic        active;
    logic [63:0] id;
    logic [63:0] expiry;
    logic [31:0] tag;
  } store_rd_t;

endpackage

// ===== hdl/expiring_notice_slot_table.sv =====
// Expiring notice slot table: one request at a time, in_ready_o high only when idle.
// Steps from accept to result register: notify with text does the multiply, the radix-16
// divide by 1000, a sweep of every slot, a scan that stops at the first free slot, the write
// and the handoff; sweep and count only sweep; get sweeps and then scans; dismiss only scans.
// The sweep and the scans visit the slots one at a time through the shared comparator.
// Reset (rst_ni, async low) clears all entries, next id to 1, post count to 0, freq to 1000.
module expiring_notice_slot_table import ens_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output resp_t       out_resp_o
);

  logic [31:0]      freq_q;
  logic             out_valid_q;
  resp_t            out_resp_q;
  logic             res_valid, res_ready;
  resp_t            resp;
  store_cmd_t       cmd;
  store_rd_t        rd;
  logic [IDX_W-1:0] ridx;
  logic [CNT_W-1:0] cnt;
  logic             div_start, div_busy;
  logic [DIV_W-1:0] div_dividend, div_quot;

  // Tick frequency register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= 32'(DEF_FREQ);
    end else if (cfg_we_i) begin
      freq_q <= cfg_wdata_i;
    end
  end

  ens_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_i          (in_req_i),
    .freq_i         (freq_q),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .resp_o         (resp),
    .cmd_o          (cmd),
    .ridx_o         (ridx),
    .rd_i           (rd),
    .cnt_i          (cnt),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_busy_i     (div_busy),
    .div_quot_i     (div_quot)
  );

  ens_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .ridx_i (ridx),
    .rd_o   (rd),
    .cnt_o  (cnt)
  );

  ens_divk u_divk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // Output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_resp_q <= resp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_resp_o  = out_resp_q;

endmodule

// ===== hdl/ens_store.sv =====
module ens_store import ens_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  store_cmd_t       cmd_i,
  input  logic [IDX_W-1:0] ridx_i,
  output store_rd_t        rd_o,
  output logic [CNT_W-1:0] cnt_o
);

  logic [SLOTS-1:0] active_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [63:0]      id_q  [SLOTS];
  logic [63:0]      exp_q [SLOTS];
  logic [31:0]      tag_q [SLOTS];

  // Running count of active entries
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.wr && !active_q[cmd_i.widx]) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.clr && active_q[cmd_i.widx]) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  // Active bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.wr) begin
        active_q[cmd_i.widx] <= 1'b1;
      end else if (cmd_i.clr) begin
        active_q[cmd_i.widx] <= 1'b0;
      end
    end
  end

  // Entry payload, only meaningful while active
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      id_q[cmd_i.widx]  <= cmd_i.id;
      exp_q[cmd_i.widx] <= cmd_i.expiry;
      tag_q[cmd_i.widx] <= cmd_i.tag;
    end
  end

  assign rd_o.active = active_q[ridx_i];
  assign rd_o.id     = id_q[ridx_i];
  assign rd_o.expiry = exp_q[ridx_i];
  assign rd_o.tag    = tag_q[ridx_i];
  assign cnt_o       = cnt_q;

  a_cnt_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CNT_W'($countones(active_q)))
    else $error("active count out of step with active bits");

endmodule

// ===== hdl/ens_divk.sv =====
module ens_divk import ens_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  output logic             busy_o,
  output logic [DIV_W-1:0] quot_o
);

  localparam logic [REM_W:0] DivK = (REM_W + 1)'(MS_PER_S);

  logic [DIV_W-1:0]    num_q, num_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [STEP_W-1:0]   step_q;
  logic                busy_q;

  // Several restoring steps per cycle; quotient bits shift in at the bottom
  always_comb begin
    logic [REM_W:0]    r;
    logic [DIV_BITS-1:0] qd;
    r  = {1'b0, rem_q};
    qd = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      r = {r[REM_W-1:0], num_q[DIV_W-1-i]};
      if (r >= DivK) begin
        r = r - DivK;
        qd[DIV_BITS-1-i] = 1'b1;
      end
    end
    rem_d = r[REM_W-1:0];
    num_d = {num_q[DIV_W-DIV_BITS-1:0], qd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == STEP_W'(DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = num_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

// ===== hdl/ens_seq.sv =====
module ens_seq import ens_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  req_t             req_i,
  input  logic [31:0]      freq_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output resp_t            resp_o,
  output store_cmd_t       cmd_o,
  output logic [IDX_W-1:0] ridx_o,
  input  store_rd_t        rd_i,
  input  logic [CNT_W-1:0] cnt_i,
  output logic             div_start_o,
  output logic [DIV_W-1:0] div_dividend_o,
  input  logic             div_busy_i,
  input  logic [DIV_W-1:0] div_quot_i
);

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] sel_q, sel_d;
  logic [IDX_W-1:0] min_idx_q, min_idx_d;
  logic [63:0]      min_id_q, min_id_d;
  logic [63:0]      next_id_q, next_id_d;
  logic [63:0]      post_q, post_d;
  logic             status_q, status_d;
  logic [5:0]       slot_q, slot_d;
  logic [63:0]      id_q, id_d;
  logic [63:0]      exp_q, exp_d;
  logic [31:0]      tag_q, tag_d;

  logic [63:0] cmp_a, cmp_b;
  logic        cmp_lt, cmp_eq;
  logic        last;
  logic [31:0] f_eff, ms_eff;
  logic [63:0] ticks;

  // Lifetime to ticks: product here, divide by 1000 in the divider
  assign f_eff          = (freq_i == '0) ? 32'(DEF_FREQ) : freq_i;
  assign ms_eff         = (req_q.lifetime_ms == '0) ? 32'(DEF_LIFE_MS) : req_q.lifetime_ms;
  assign div_dividend_o = f_eff * ms_eff;
  assign ticks          = (div_quot_i == '0) ? 64'd1 : div_quot_i;

  // Shared 64-bit comparator
  always_comb begin
    if (state_q == ST_SWEEP) begin
      cmp_a = rd_i.expiry;
      cmp_b = req_q.now_tick;
    end else begin
      cmp_a = rd_i.id;
      cmp_b = (req_q.op == OP_DISMISS) ? req_q.target_id : min_id_q;
    end
  end
  assign cmp_lt = cmp_a < cmp_b;
  assign cmp_eq = cmp_a == cmp_b;

  assign last   = (idx_q == IDX_W'(SLOTS - 1));
  assign ridx_o = idx_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    sel_d       = sel_q;
    min_idx_d   = min_idx_q;
    min_id_d    = min_id_q;
    next_id_d   = next_id_q;
    post_d      = post_q;
    status_d    = status_q;
    slot_d      = slot_q;
    id_d        = id_q;
    exp_d       = exp_q;
    tag_d       = tag_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    div_start_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d    = req_i;
          idx_d    = '0;
          cur_d    = '0;
          status_d = 1'b1;
          slot_d   = '0;
          id_d     = '0;
          exp_d    = '0;
          tag_d    = '0;
          unique case (req_i.op) inside
            OP_NOTIFY:                 state_d = req_i.has_text ? ST_MUL : ST_DONE;
            OP_SWEEP, OP_COUNT, OP_GET: state_d = ST_SWEEP;
            OP_DISMISS:                state_d = ST_SCAN;
            default:                   state_d = ST_DONE;
          endcase
        end
      end

      ST_MUL: begin
        div_start_o = 1'b1;
        state_d     = ST_DIV;
      end

      ST_DIV: begin
        if (!div_busy_i) begin
          idx_d   = '0;
          state_d = ST_SWEEP;
        end
      end

      // Retire expired entries, one slot a cycle
      ST_SWEEP: begin
        if (rd_i.active && (cmp_lt || cmp_eq)) begin
          cmd_o.clr  = 1'b1;
          cmd_o.widx = idx_q;
        end
        if (last) begin
          idx_d = '0;
          if (req_q.op == OP_NOTIFY || req_q.op == OP_GET) begin
            state_d = ST_SCAN;
          end else begin
            status_d = 1'b0;
            state_d  = ST_DONE;
          end
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      // Search pass: free/oldest slot, id match or nth active
      ST_SCAN: begin
        unique case (req_q.op) inside
          OP_NOTIFY: begin
            if (!rd_i.active) begin
              sel_d   = idx_q;
              state_d = ST_WRITE;
            end else begin
              if (idx_q == '0 || cmp_lt) begin
                min_id_d  = rd_i.id;
                min_idx_d = idx_q;
              end
              if (last) begin
                sel_d   = (idx_q == '0 || cmp_lt) ? idx_q : min_idx_q;
                state_d = ST_WRITE;
              end else begin
                idx_d = idx_q + IDX_W'(1);
              end
            end
          end
          OP_DISMISS: begin
            if (rd_i.active && cmp_eq) begin
              cmd_o.clr  = 1'b1;
              cmd_o.widx = idx_q;
              status_d   = 1'b0;
              slot_d     = 6'(idx_q);
              id_d       = rd_i.id;
              exp_d      = rd_i.expiry;
              tag_d      = rd_i.tag;
              state_d    = ST_DONE;
            end else if (last) begin
              state_d = ST_DONE;
            end else begin
              idx_d = idx_q + IDX_W'(1);
            end
          end
          OP_GET: begin
            if (rd_i.active && req_q.nth == 6'(cur_q)) begin
              status_d = 1'b0;
              slot_d   = 6'(idx_q);
              id_d     = rd_i.id;
              exp_d    = rd_i.expiry;
              tag_d    = rd_i.tag;
              state_d  = ST_DONE;
            end else begin
              if (rd_i.active) begin
                cur_d = cur_q + IDX_W'(1);
              end
              if (last) begin
                state_d = ST_DONE;
              end else begin
                idx_d = idx_q + IDX_W'(1);
              end
            end
          end
          default: state_d = ST_DONE;
        endcase
      end

      ST_WRITE: begin
        cmd_o.wr     = 1'b1;
        cmd_o.widx   = sel_q;
        cmd_o.id     = next_id_q;
        cmd_o.expiry = req_q.now_tick + ticks;
        cmd_o.tag    = req_q.message_tag;
        status_d     = 1'b0;
        slot_d       = 6'(sel_q);
        id_d         = next_id_q;
        exp_d        = req_q.now_tick + ticks;
        tag_d        = req_q.message_tag;
        next_id_d    = next_id_q + 64'd1;
        post_d       = post_q + 64'd1;
        state_d      = ST_DONE;
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      next_id_q <= 64'd1;
      post_q    <= '0;
    end else begin
      state_q   <= state_d;
      next_id_q <= next_id_d;
      post_q    <= post_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    idx_q     <= idx_d;
    cur_q     <= cur_d;
    sel_q     <= sel_d;
    min_idx_q <= min_idx_d;
    min_id_q  <= min_id_d;
    status_q  <= status_d;
    slot_q    <= slot_d;
    id_q      <= id_d;
    exp_q     <= exp_d;
    tag_q     <= tag_d;
  end

  // Result of the finished request
  always_comb begin
    resp_o              = '0;
    resp_o.status       = status_q;
    resp_o.slot         = slot_q;
    resp_o.entry_id     = id_q;
    resp_o.expiry_tick  = exp_q;
    resp_o.entry_tag    = tag_q;
    resp_o.active_count = 7'(cnt_i);
    resp_o.posted_total = post_q;
  end

  a_wr_clr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.wr && cmd_o.clr))
    else $error("store written and cleared in one cycle");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while another is in progress");

  a_post_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |=> (post_q == $past(post_q) + 64'd1))
    else $error("post count did not advance on notify");

endmodule
